FILE: rtl/core/jwd_pkg.sv
// Shared types and codes of the job dispatcher.
`timescale 1ns / 1ps

package jwd_pkg;

    localparam logic [1:0] ACT_SUBMIT = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;

    localparam logic [2:0] ST_STARTED   = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_IDLED     = 3'd5;
    localparam logic [2:0] ST_IGNORED   = 3'd6;

    typedef struct packed {
        logic [31:0] task_h;
        logic [31:0] param_h;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
        logic cancel;
        t_job job;
    } t_q_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_q_stat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_pool_cmd;

endpackage

FILE: rtl/core/jwd_job_queue.sv
// Job queue: circular buffer in a synchronous memory with cancel search and compaction.
`timescale 1ns / 1ps

module jwd_job_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  jwd_pkg::t_q_cmd                  i_cmd,
    output jwd_pkg::t_q_stat                 o_stat,
    output jwd_pkg::t_job                    o_head_job,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_fill
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {Q_IDLE, Q_SRCH, Q_MOVE} t_q_state;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    jwd_pkg::t_job mem [QUEUE_DEPTH];
    jwd_pkg::t_job r_rdata;
    jwd_pkg::t_job r_key;
    t_q_state      r_state;
    logic [AW-1:0] r_head, r_tail, r_ptr, r_src, r_dst, r_wr_ptr;
    logic [FW-1:0] r_fill, r_left, r_sk;
    logic          r_wr_pend, r_done, r_found;
    logic          n_done;

    logic          w_we, w_re, w_match;
    logic [AW-1:0] w_waddr, w_raddr;
    jwd_pkg::t_job w_wdata;

    assign w_match = (r_rdata == r_key);

    // cancel ends on an empty queue, on a search that runs out, or after the last move
    assign n_done = ((r_state == Q_IDLE) && !i_cmd.push && !i_cmd.pop && i_cmd.cancel &&
                     (r_fill == '0)) ||
                    ((r_state == Q_SRCH) && !w_match && (r_left == '0)) ||
                    ((r_state == Q_MOVE) && (r_left == '0));

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_tail;
        w_raddr = r_head;
        w_wdata = i_cmd.job;
        unique case (r_state)
            Q_IDLE: begin
                if (i_cmd.push) begin
                    w_we = 1'b1;
                end else if (i_cmd.pop) begin
                    w_re = 1'b1;
                end else if (i_cmd.cancel && r_fill != '0) begin
                    w_re    = 1'b1;
                    w_raddr = ptr_dec(r_tail);
                end
            end
            Q_SRCH: begin
                w_re    = !w_match && r_left != '0;
                w_raddr = ptr_dec(r_ptr);
            end
            Q_MOVE: begin
                w_we    = r_wr_pend;
                w_waddr = r_wr_ptr;
                w_wdata = r_rdata;
                w_re    = r_left != '0;
                w_raddr = r_src;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= Q_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_wr_pend <= 1'b0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                Q_IDLE: begin
                    if (i_cmd.push) begin
                        r_tail <= ptr_inc(r_tail);
                        r_fill <= r_fill + FW'(1);
                    end else if (i_cmd.pop) begin
                        r_head <= ptr_inc(r_head);
                        r_fill <= r_fill - FW'(1);
                    end else if (i_cmd.cancel) begin
                        if (r_fill == '0) begin
                            r_found <= 1'b0;
                        end else begin
                            r_state <= Q_SRCH;
                            r_ptr   <= ptr_dec(r_tail);
                            r_sk    <= '0;
                            r_left  <= r_fill - FW'(1);
                            r_key   <= i_cmd.job;
                        end
                    end
                end
                Q_SRCH: begin
                    if (w_match) begin
                        // shift the newer entries down over the match
                        r_state   <= Q_MOVE;
                        r_src     <= ptr_inc(r_ptr);
                        r_dst     <= r_ptr;
                        r_left    <= r_sk;
                        r_wr_pend <= 1'b0;
                    end else if (r_left == '0) begin
                        r_state <= Q_IDLE;
                        r_found <= 1'b0;
                    end else begin
                        r_ptr  <= ptr_dec(r_ptr);
                        r_sk   <= r_sk + FW'(1);
                        r_left <= r_left - FW'(1);
                    end
                end
                Q_MOVE: begin
                    if (r_left != '0) begin
                        r_src     <= ptr_inc(r_src);
                        r_dst     <= ptr_inc(r_dst);
                        r_wr_ptr  <= r_dst;
                        r_wr_pend <= 1'b1;
                        r_left    <= r_left - FW'(1);
                    end else begin
                        r_wr_pend <= 1'b0;
                        r_tail    <= ptr_dec(r_tail);
                        r_fill    <= r_fill - FW'(1);
                        r_state   <= Q_IDLE;
                        r_found   <= 1'b1;
                    end
                end
                default: begin
                    r_state <= Q_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_head_job   = r_rdata;
    assign o_fill       = r_fill;

endmodule

FILE: rtl/core/jwd_idle_pool.sv
// Idle worker FIFO and busy mask.
`timescale 1ns / 1ps

module jwd_idle_pool #(
    parameter int NUM_WORKERS = 8,
    parameter int WIDX        = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  jwd_pkg::t_pool_cmd               i_cmd,
    input  logic [WIDX-1:0]                  i_push_worker,
    input  logic [WIDX-1:0]                  i_check_worker,
    output logic                             o_check_busy,
    output logic [WIDX-1:0]                  o_head,
    output logic [$clog2(NUM_WORKERS+1)-1:0] o_count
);

    localparam int CW = $clog2(NUM_WORKERS + 1);
    localparam logic [WIDX-1:0] LAST = WIDX'(NUM_WORKERS - 1);

    function automatic logic [WIDX-1:0] ptr_inc(input logic [WIDX-1:0] p);
        return (p == LAST) ? '0 : p + WIDX'(1);
    endfunction

    logic [WIDX-1:0]        r_order [NUM_WORKERS];
    logic [WIDX-1:0]        r_head, r_tail;
    logic [CW-1:0]          r_count;
    logic [NUM_WORKERS-1:0] r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_order[i] <= WIDX'(i);
            end
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= CW'(NUM_WORKERS);
            r_busy  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_order[r_tail]       <= i_push_worker;
                r_tail                <= ptr_inc(r_tail);
                r_count               <= r_count + CW'(1);
                r_busy[i_push_worker] <= 1'b0;
            end else if (i_cmd.pop) begin
                r_head                          <= ptr_inc(r_head);
                r_count                         <= r_count - CW'(1);
                r_busy[r_order[r_head]]         <= 1'b1;
            end
        end
    end

    assign o_check_busy = r_busy[i_check_worker];
    assign o_head       = r_order[r_head];
    assign o_count      = r_count;

endmodule

FILE: rtl/core/job_to_idle_worker_dispatcher_unit.sv
// Top level of the job dispatcher: request decode, sequencing and result register.
`timescale 1ns / 1ps
// Sequence: an accepted request is decoded in S_EXEC and its result is registered from
// S_OUT once the output is free; a finish with dispatch passes S_FIN_POP (job memory read),
// a cancel waits in S_QWAIT for the search over the job memory, one entry a cycle, and the compaction.
// Throughput: one request at a time, a new one only in S_IDLE; the next is taken while the
// previous result still waits.
// Synchronous active-low reset: queue empty, all workers idle in order 0 upwards.

module job_to_idle_worker_dispatcher_unit #(
    parameter int NUM_WORKERS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_task_handle,
    input  logic [31:0] i_param_handle,
    input  logic [2:0]  i_worker_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_dispatched,
    output logic [2:0]  o_dispatch_worker,
    output logic [31:0] o_dispatch_task,
    output logic [31:0] o_dispatch_param,
    output logic [4:0]  o_queued_jobs
);

    localparam int WIDX = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int WEW  = WIDX + 3;
    localparam int CW   = $clog2(NUM_WORKERS + 1);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FIN_POP, S_QWAIT, S_OUT} t_state;

    t_state      r_state;
    logic [1:0]  r_action;
    logic [31:0] r_task, r_param;
    logic [2:0]  r_wid;
    logic [2:0]  r_res_status;
    logic        r_res_disp;
    logic [2:0]  r_res_worker;
    logic [31:0] r_res_task, r_res_param;

    jwd_pkg::t_q_cmd    w_q_cmd;
    jwd_pkg::t_q_stat   w_q_stat;
    jwd_pkg::t_job      w_q_head;
    logic [FW-1:0]      w_q_fill;
    jwd_pkg::t_pool_cmd w_p_cmd;
    logic               w_p_busy;
    logic [WIDX-1:0]    w_p_head;
    logic [CW-1:0]      w_p_count;

    logic [WEW-1:0]     w_wid_ext;
    logic               w_wid_ok;
    logic               w_finish_ok;
    logic               w_start_now;
    logic               w_submit_start;
    logic               w_out_free;

    assign w_wid_ext      = {{WIDX{1'b0}}, r_wid};
    assign w_wid_ok       = w_wid_ext < WEW'(NUM_WORKERS);
    assign w_finish_ok    = w_wid_ok && w_p_busy;
    assign w_start_now    = (w_p_count != '0) && (w_q_fill == '0);
    assign w_submit_start = (r_action == jwd_pkg::ACT_SUBMIT) && w_start_now;
    assign w_out_free     = !o_out_valid || !i_out_stall;
    assign o_in_stall     = (r_state != S_IDLE);

    always_comb begin
        w_q_cmd.push   = 1'b0;
        w_q_cmd.pop    = 1'b0;
        w_q_cmd.cancel = 1'b0;
        w_q_cmd.job    = '{task_h: r_task, param_h: r_param};
        w_p_cmd.push   = 1'b0;
        w_p_cmd.pop    = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_action)
                    jwd_pkg::ACT_SUBMIT: begin
                        if (w_start_now) begin
                            w_p_cmd.pop = 1'b1;
                        end else if (w_q_fill < FW'(QUEUE_DEPTH)) begin
                            w_q_cmd.push = 1'b1;
                        end
                    end
                    jwd_pkg::ACT_FINISH: begin
                        if (w_finish_ok) begin
                            w_p_cmd.push = 1'b1;
                            w_q_cmd.pop  = (w_q_fill != '0);
                        end
                    end
                    jwd_pkg::ACT_CANCEL: begin
                        w_q_cmd.cancel = 1'b1;
                    end
                    default: begin
                        w_q_cmd.cancel = 1'b0;
                    end
                endcase
            end
            S_FIN_POP: begin
                w_p_cmd.pop = 1'b1;
            end
            default: begin
                w_p_cmd.pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= i_action;
                        r_task   <= i_task_handle;
                        r_param  <= i_param_handle;
                        r_wid    <= i_worker_id;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_disp   <= w_submit_start;
                    r_res_worker <= w_submit_start ? 3'(w_p_head) : 3'd0;
                    r_res_task   <= w_submit_start ? r_task : 32'd0;
                    r_res_param  <= w_submit_start ? r_param : 32'd0;
                    unique case (r_action)
                        jwd_pkg::ACT_SUBMIT: begin
                            r_state <= S_OUT;
                            if (w_start_now) begin
                                r_res_status <= jwd_pkg::ST_STARTED;
                            end else if (w_q_fill < FW'(QUEUE_DEPTH)) begin
                                r_res_status <= jwd_pkg::ST_QUEUED;
                            end else begin
                                r_res_status <= jwd_pkg::ST_REJECTED;
                            end
                        end
                        jwd_pkg::ACT_FINISH: begin
                            if (w_finish_ok) begin
                                r_res_status <= jwd_pkg::ST_IDLED;
                                r_state      <= (w_q_fill != '0) ? S_FIN_POP : S_OUT;
                            end else begin
                                r_res_status <= jwd_pkg::ST_IGNORED;
                                r_state      <= S_OUT;
                            end
                        end
                        jwd_pkg::ACT_CANCEL: begin
                            r_state <= S_QWAIT;
                        end
                        default: begin
                            r_res_status <= jwd_pkg::ST_NOT_FOUND;
                            r_state      <= S_OUT;
                        end
                    endcase
                end
                S_FIN_POP: begin
                    // oldest job goes to the head idle worker
                    r_res_disp   <= 1'b1;
                    r_res_worker <= 3'(w_p_head);
                    r_res_task   <= w_q_head.task_h;
                    r_res_param  <= w_q_head.param_h;
                    r_state      <= S_OUT;
                end
                S_QWAIT: begin
                    if (w_q_stat.done) begin
                        r_res_status <= w_q_stat.found ? jwd_pkg::ST_CANCELLED
                                                       : jwd_pkg::ST_NOT_FOUND;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_out_valid       <= 1'b1;
                        o_status          <= r_res_status;
                        o_dispatched      <= r_res_disp;
                        o_dispatch_worker <= r_res_worker;
                        o_dispatch_task   <= r_res_task;
                        o_dispatch_param  <= r_res_param;
                        o_queued_jobs     <= 5'(w_q_fill);
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    jwd_job_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_q_cmd),
        .o_stat     (w_q_stat),
        .o_head_job (w_q_head),
        .o_fill     (w_q_fill)
    );

    jwd_idle_pool #(
        .NUM_WORKERS(NUM_WORKERS),
        .WIDX       (WIDX)
    ) u_pool (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_p_cmd),
        .i_push_worker  (w_wid_ext[WIDX-1:0]),
        .i_check_worker (w_wid_ext[WIDX-1:0]),
        .o_check_busy   (w_p_busy),
        .o_head         (w_p_head),
        .o_count        (w_p_count)
    );

endmodule
